### design/adler32_checked_frame_deframer_core_macros.svh
// Assertion macros shared by the deframer RTL.
`ifndef ADLER32_CHECKED_FRAME_DEFRAMER_CORE_MACROS_SVH
`define ADLER32_CHECKED_FRAME_DEFRAMER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ACFD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ACFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/acfd_pkg.sv
// Types and constants shared by the Adler-32 checked frame deframer.
package acfd_pkg;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_BODY,
    PH_HALT
  } phase_e;

  typedef struct packed {
    logic [15:0] high;
    logic [15:0] low;
  } adler_sum_t;

  localparam int unsigned LEN_W = 32;
  localparam int unsigned CFG_W = 31;

  localparam logic [16:0] ADLER_MOD = 17'd65521;
  localparam adler_sum_t ADLER_INIT = '{high: 16'd0, low: 16'd1};

  localparam logic [CFG_W-1:0] MIN_LEN_RST = 31'd10;
  localparam logic [CFG_W-1:0] MAX_LEN_RST = 31'd67108864;

  localparam logic [LEN_W-1:0] MIN_BODY_LEN = 32'd8;
  localparam logic [LEN_W-1:0] MIN_NAME_LEN = 32'd2;

  // Configuration register indexes.
  localparam logic REG_MIN_LEN = 1'b0;
  localparam logic REG_MAX_LEN = 1'b1;

  // Result region codes.
  localparam logic [1:0] REGION_NAME   = 2'd0;
  localparam logic [1:0] REGION_DATA   = 2'd1;
  localparam logic [1:0] REGION_STATUS = 2'd2;

  // Frame status codes.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_LEN      = 2'd1;
  localparam logic [1:0] STATUS_CHECKSUM = 2'd2;
  localparam logic [1:0] STATUS_NAME_LEN = 2'd3;

endpackage

### design/acfd_adler.sv
// One Adler-32 update step: folds one byte into the running sums.
module acfd_adler (
  input  acfd_pkg::adler_sum_t sum_i,
  input  logic [7:0]           byte_i,
  output acfd_pkg::adler_sum_t sum_o
);
  import acfd_pkg::*;

  logic [16:0] low_sum;
  logic [15:0] low_new;
  logic [16:0] high_sum;

  // Both sums stay below the modulus, so one conditional subtraction reduces each.
  always_comb begin
    low_sum    = {1'b0, sum_i.low} + {9'd0, byte_i};
    low_new    = (low_sum >= ADLER_MOD) ? 16'(low_sum - ADLER_MOD) : low_sum[15:0];
    high_sum   = {1'b0, sum_i.high} + {1'b0, low_new};
    sum_o.low  = low_new;
    sum_o.high = (high_sum >= ADLER_MOD) ? 16'(high_sum - ADLER_MOD) : high_sum[15:0];
  end

endmodule

### design/adler32_checked_frame_deframer_core.sv
// Adler-32 checked frame deframer: takes one stream byte per clock, while the output
// register is not held by a stall, into an input register, processes it in a single
// stage against the frame state and places any result (a name byte, a data byte or a
// frame status record) in an output register, so a byte's result passes through the
// input register and then the output register. A frame whose length violates the
// configured bounds or the minimum body length, fails its checksum or carries a bad
// name length ends with a status record, after which every byte is dropped until
// reset. Configuration writes are meant for idle periods only.
module adler32_checked_frame_deframer_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [acfd_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 data_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [7:0]                 out_byte_o,
  output logic [1:0]                 region_o,
  output logic [1:0]                 status_o
);
  import acfd_pkg::*;

`include "adler32_checked_frame_deframer_core_macros.svh"

  logic [CFG_W-1:0] min_len_q, max_len_q;

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_fire, proc_fire;

  phase_e           phase_q, phase_d;
  logic [LEN_W-1:0] byte_count_q, byte_count_d;
  logic [LEN_W-1:0] frame_len_q, frame_len_d;
  logic [LEN_W-1:0] name_len_q, name_len_d;
  logic [LEN_W-1:0] expected_q, expected_d;
  logic [LEN_W-1:0] chk_start_q, chk_start_d;
  logic [LEN_W-1:0] last_pos_q, last_pos_d;
  logic [LEN_W-1:0] name_term_q, name_term_d;
  logic             name_ok_q, name_ok_d;
  adler_sum_t       adler_q, adler_d, adler_next;

  logic [LEN_W-1:0] hdr_len, name_len_new, exp_new;
  logic             hdr_last, len_bad, in_sum_region, name_ok_new, last_byte;
  logic             past_len_field;
  logic [1:0]       end_status;

  logic       res_valid;
  logic [7:0] res_byte;
  logic [1:0] res_region, res_status;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic [1:0] region_q, status_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= MIN_LEN_RST;
      max_len_q <= MAX_LEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MIN_LEN: min_len_q <= cfg_wdata_i;
        REG_MAX_LEN: max_len_q <= cfg_wdata_i;
      endcase
    end
  end

  // The processing stage moves when the output register is free or being drained.
  assign proc_fire  = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !proc_fire;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (proc_fire) begin
      in_valid_d = 1'b0;
    end
  end

  acfd_adler u_adler (
    .sum_i  (adler_q),
    .byte_i (in_byte_q),
    .sum_o  (adler_next)
  );

  // Shared decode of the byte under processing.
  always_comb begin
    hdr_len        = {frame_len_q[23:0], in_byte_q};
    hdr_last       = (byte_count_q[1:0] == 2'd3);
    len_bad        = (hdr_len > {1'b0, max_len_q}) || (hdr_len < {1'b0, min_len_q}) ||
                     (hdr_len < MIN_BODY_LEN);
    in_sum_region  = (byte_count_q < chk_start_q);
    past_len_field = |byte_count_q[LEN_W-1:2];
    name_len_new   = {name_len_q[23:0], in_byte_q};
    name_ok_new    = (name_len_new >= MIN_NAME_LEN) &&
                     (({1'b0, name_len_new} + 33'd8) <= {1'b0, frame_len_q});
    exp_new        = {expected_q[23:0], in_byte_q};
    last_byte      = (byte_count_q == last_pos_q);
    if (adler_q != exp_new) begin
      end_status = STATUS_CHECKSUM;
    end else if (!name_ok_q) begin
      end_status = STATUS_NAME_LEN;
    end else begin
      end_status = STATUS_OK;
    end
  end

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_HEADER: begin
        if (proc_fire && hdr_last) begin
          phase_d = len_bad ? PH_HALT : PH_BODY;
        end
      end
      PH_BODY: begin
        if (proc_fire && !in_sum_region && last_byte) begin
          phase_d = (end_status != STATUS_OK) ? PH_HALT : PH_HEADER;
        end
      end
      PH_HALT: phase_d = PH_HALT;
      default: phase_d = PH_HEADER;
    endcase
  end

  // Result of the byte under processing.
  always_comb begin
    res_valid  = 1'b0;
    res_byte   = 8'd0;
    res_region = REGION_STATUS;
    res_status = STATUS_OK;
    unique case (phase_q)
      PH_HEADER: begin
        if (proc_fire && hdr_last && len_bad) begin
          res_valid  = 1'b1;
          res_status = STATUS_LEN;
        end
      end
      PH_BODY: begin
        if (proc_fire) begin
          if (in_sum_region) begin
            // The name terminator itself is not forwarded.
            if (past_len_field && name_ok_q) begin
              if (byte_count_q < name_term_q) begin
                res_valid  = 1'b1;
                res_byte   = in_byte_q;
                res_region = REGION_NAME;
              end else if (byte_count_q > name_term_q) begin
                res_valid  = 1'b1;
                res_byte   = in_byte_q;
                res_region = REGION_DATA;
              end
            end
          end else if (last_byte) begin
            res_valid  = 1'b1;
            res_status = end_status;
          end
        end
      end
      PH_HALT: res_valid = 1'b0;
      default: res_valid = 1'b0;
    endcase
  end

  // Frame datapath.
  always_comb begin
    byte_count_d = byte_count_q;
    frame_len_d  = frame_len_q;
    name_len_d   = name_len_q;
    expected_d   = expected_q;
    chk_start_d  = chk_start_q;
    last_pos_d   = last_pos_q;
    name_term_d  = name_term_q;
    name_ok_d    = name_ok_q;
    adler_d      = adler_q;
    if (proc_fire) begin
      case (phase_q)
        PH_HEADER: begin
          frame_len_d  = hdr_len;
          byte_count_d = hdr_last ? '0 : byte_count_q + 32'd1;
          if (hdr_last) begin
            adler_d     = ADLER_INIT;
            name_len_d  = '0;
            expected_d  = '0;
            chk_start_d = hdr_len - 32'd4;
            last_pos_d  = hdr_len - 32'd1;
          end
        end
        PH_BODY: begin
          byte_count_d = byte_count_q + 32'd1;
          if (in_sum_region) begin
            adler_d = adler_next;
            if (!past_len_field) begin
              name_len_d = name_len_new;
            end
            if (hdr_last && !past_len_field) begin
              name_ok_d   = name_ok_new;
              name_term_d = name_len_new + 32'd3;
            end
          end else begin
            expected_d = exp_new;
            if (last_byte) begin
              byte_count_d = '0;
              frame_len_d  = '0;
            end
          end
        end
        default: byte_count_d = byte_count_q;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (proc_fire) begin
      out_valid_d = res_valid;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      phase_q      <= PH_HEADER;
      byte_count_q <= '0;
      frame_len_q  <= '0;
    end else begin
      in_valid_q   <= in_valid_d;
      out_valid_q  <= out_valid_d;
      phase_q      <= phase_d;
      byte_count_q <= byte_count_d;
      frame_len_q  <= frame_len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= data_byte_i;
    end
    if (proc_fire && res_valid) begin
      out_byte_q <= res_byte;
      region_q   <= res_region;
      status_q   <= res_status;
    end
    name_len_q  <= name_len_d;
    expected_q  <= expected_d;
    chk_start_q <= chk_start_d;
    last_pos_q  <= last_pos_d;
    name_term_q <= name_term_d;
    name_ok_q   <= name_ok_d;
    adler_q     <= adler_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign region_o    = region_q;
  assign status_o    = status_q;

  `ACFD_ASSERT_NEXT(a_halt_sticky, phase_q == PH_HALT, phase_q == PH_HALT, "halt was left")
  `ACFD_ASSERT_NEXT(a_halt_reports, (phase_q != PH_HALT) && (phase_d == PH_HALT),
                    out_valid_o && (region_o == REGION_STATUS) && (status_o != STATUS_OK),
                    "halt entered without an error record")
  `ACFD_ASSERT_IMPL(a_bytes_clean, out_valid_o && (region_o != REGION_STATUS),
                    (status_o == STATUS_OK) &&
                    ((region_o == REGION_NAME) || (region_o == REGION_DATA)),
                    "byte record with bad region or status")

endmodule

### bench/tb_adler32_checked_frame_deframer_core.sv
// Self-checking testbench for the Adler-32 checked frame deframer core.
`timescale 1ns / 1ps

module tb_adler32_checked_frame_deframer_core;
  import acfd_pkg::*;

  localparam int unsigned ADLER_MODULUS = 65521;
  localparam int unsigned IDLE_LIMIT    = 2000;
  localparam int unsigned RANDOM_BYTES  = 400;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] region;
    logic [1:0] status;
  } frame_rec_t;

  typedef enum int {
    FILL_RANDOM,
    FILL_ONES,
    FILL_ZEROS
  } fill_e;

  typedef enum int {
    FAULT_ABOVE_MAX,
    FAULT_BELOW_MIN,
    FAULT_SHORT_BODY,
    FAULT_CHECKSUM,
    FAULT_NAME_SHORT,
    FAULT_NAME_LONG,
    FAULT_NAME_NEG,
    FAULT_CHECKSUM_AND_NAME
  } fault_e;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic             cfg_idx_i;
  logic [CFG_W-1:0] cfg_wdata_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [7:0]       data_byte_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [7:0]       out_byte_o;
  logic [1:0]       region_o;
  logic [1:0]       status_o;

  // Deframer state as predicted by the bench.
  logic [CFG_W-1:0] min_len;
  logic [CFG_W-1:0] max_len;
  phase_e           frame_phase;
  logic [31:0]      byte_cnt;
  logic [31:0]      frame_len;
  logic [31:0]      name_len;
  logic [31:0]      sum_field;
  adler_sum_t       run_sum;

  frame_rec_t  pending_records[$];
  int unsigned mismatches;
  int unsigned bytes_sent;
  int unsigned burst_left;
  int unsigned idle_cycles;
  logic [9:0]  stall_tick;

  adler32_checked_frame_deframer_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .region_o    (region_o),
    .status_o    (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void post_record(input logic [7:0] ob, input logic [1:0] rg,
                                      input logic [1:0] st);
    frame_rec_t rec;
    rec.out_byte = ob;
    rec.region   = rg;
    rec.status   = st;
    pending_records = {pending_records, rec};
  endfunction

  function automatic bit name_len_ok();
    return name_len >= 32'd2 && ({1'b0, name_len} + 33'd8 <= {1'b0, frame_len});
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    logic [31:0] pos;
    logic [16:0] lo;
    logic [16:0] hi;
    logic [1:0]  st;
    case (frame_phase)
      PH_HEADER: begin
        frame_len = {frame_len[23:0], b};
        byte_cnt  = byte_cnt + 32'd1;
        if (byte_cnt == 32'd4) begin
          byte_cnt = '0;
          if (frame_len > {1'b0, max_len} || frame_len < {1'b0, min_len} ||
              frame_len < 32'd8) begin
            frame_phase = PH_HALT;
            post_record(8'h00, REGION_STATUS, STATUS_LEN);
          end else begin
            frame_phase  = PH_BODY;
            run_sum.high = 16'd0;
            run_sum.low  = 16'd1;
            name_len     = '0;
            sum_field    = '0;
          end
        end
      end
      PH_BODY: begin
        pos      = byte_cnt;
        byte_cnt = byte_cnt + 32'd1;
        if (pos < frame_len - 32'd4) begin
          lo = {1'b0, run_sum.low} + {9'd0, b};
          if (lo >= ADLER_MODULUS) lo = 17'(lo - ADLER_MODULUS);
          hi = {1'b0, run_sum.high} + lo;
          if (hi >= ADLER_MODULUS) hi = 17'(hi - ADLER_MODULUS);
          run_sum.low  = lo[15:0];
          run_sum.high = hi[15:0];
          if (pos < 32'd4) begin
            name_len = {name_len[23:0], b};
          end else if (name_len_ok()) begin
            // The last name byte is the terminator and is not forwarded.
            if ({1'b0, pos} <= {1'b0, name_len} + 33'd2) begin
              post_record(b, REGION_NAME, STATUS_OK);
            end else if ({1'b0, pos} >= {1'b0, name_len} + 33'd4) begin
              post_record(b, REGION_DATA, STATUS_OK);
            end
          end
        end else begin
          sum_field = {sum_field[23:0], b};
          if (pos == frame_len - 32'd1) begin
            if ({run_sum.high, run_sum.low} != sum_field) st = STATUS_CHECKSUM;
            else if (!name_len_ok()) st = STATUS_NAME_LEN;
            else st = STATUS_OK;
            byte_cnt    = '0;
            frame_len   = '0;
            frame_phase = (st != STATUS_OK) ? PH_HALT : PH_HEADER;
            post_record(8'h00, REGION_STATUS, st);
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("%0t ns: mismatch: %s", $realtime, msg);
  endtask

  task automatic hold_input(input int unsigned cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Always waits on the clock before checking the queue, so valid is never driven twice in one step.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_records.size() != 0);
  endtask

  task automatic pace_sender();
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(48, 1);
      if ($urandom_range(3, 0) != 0) hold_input($urandom_range(6, 1));
    end
  endtask

  // Valid stays high after a transfer; whoever next spends time lowers it first.
  task automatic send_byte(input logic [7:0] b);
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    deframe_byte(b);
    bytes_sent++;
    pace_sender();
  endtask

  task automatic send_header(input logic [31:0] len);
    int i;
    for (i = 3; i >= 0; i--) send_byte(len[8*i +: 8]);
  endtask

  task automatic send_frame(input logic [31:0] name_field, input int unsigned mid_n,
                            input fill_e fill, input bit bad_sum);
    logic [7:0]  body[$];
    logic [7:0]  v;
    logic [31:0] a;
    logic [31:0] s;
    logic [31:0] chk;
    int          i;
    for (i = 3; i >= 0; i--) body = {body, name_field[8*i +: 8]};
    for (i = 0; i < int'(mid_n); i++) begin
      case (fill)
        FILL_ONES:  v = 8'hFF;
        FILL_ZEROS: v = 8'h00;
        default:    v = $urandom_range(255, 0);
      endcase
      body = {body, v};
    end
    a = 32'd1;
    s = 32'd0;
    foreach (body[k]) begin
      a = (a + body[k]) % ADLER_MODULUS;
      s = (s + a) % ADLER_MODULUS;
    end
    chk = {s[15:0], a[15:0]};
    if (bad_sum) chk = chk ^ (32'd1 << $urandom_range(31, 0));
    for (i = 3; i >= 0; i--) body = {body, chk[8*i +: 8]};
    send_header(body.size());
    foreach (body[k]) send_byte(body[k]);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
    drain_results();
    // Header bytes produce no record, so give the pipeline time to empty.
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_MIN_LEN) min_len = value;
    else max_len = value;
  endtask

  task automatic test_directed();
    // Shortest legal frame: one name byte and its terminator, no data.
    send_frame(32'd2, 2, FILL_ZEROS, 1'b0);
    // Name reaching right up to the checksum.
    send_frame(32'd6, 6, FILL_ONES, 1'b0);
    send_frame(32'd2, 4, FILL_RANDOM, 1'b0);
  endtask

  task automatic test_bounds();
    write_reg(REG_MIN_LEN, '0);
    write_reg(REG_MAX_LEN, 31'h7FFF_FFFF);
    send_frame(32'd2, 3, FILL_RANDOM, 1'b0);
    // Both bounds pinned to one length.
    write_reg(REG_MIN_LEN, 31'd13);
    write_reg(REG_MAX_LEN, 31'd13);
    send_frame(32'd3, 5, FILL_RANDOM, 1'b0);
    write_reg(REG_MIN_LEN, MIN_LEN_RST);
    write_reg(REG_MAX_LEN, MAX_LEN_RST);
  endtask

  task automatic test_sum_wrap();
    // Enough all-ones bytes to push the low sum past the modulus.
    send_frame(32'd5, 300, FILL_ONES, 1'b0);
    drain_results();
  endtask

  task automatic test_random();
    int unsigned start;
    int unsigned mid;
    int unsigned r;
    fill_e       fill;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      if ($urandom_range(9, 0) == 0) begin
        if ($urandom_range(1, 0) == 0) begin
          write_reg(REG_MIN_LEN, CFG_W'($urandom_range(10, 0)));
        end else begin
          case ($urandom_range(2, 0))
            0:       write_reg(REG_MAX_LEN, 31'h7FFF_FFFF);
            1:       write_reg(REG_MAX_LEN, 31'd400);
            default: write_reg(REG_MAX_LEN, CFG_W'($urandom_range(32'h7FFF_FFFF, 400)));
          endcase
        end
      end
      if ($urandom_range(11, 0) == 0) drain_results();
      if ($urandom_range(19, 0) == 0) begin
        mid  = $urandom_range(330, 260);
        fill = ($urandom_range(1, 0) == 0) ? FILL_ONES : FILL_RANDOM;
      end else begin
        mid = $urandom_range(24, 2);
        r   = $urandom_range(9, 0);
        fill = (r == 8) ? FILL_ONES : (r == 9) ? FILL_ZEROS : FILL_RANDOM;
      end
      send_frame($urandom_range(mid, 2), mid, fill, 1'b0);
    end
  endtask

  // Any fault halts the block for good, so one is picked and sent last.
  task automatic test_fault();
    fault_e      fault;
    int unsigned mid;
    int          i;
    fault = fault_e'($urandom_range(7, 0));
    mid   = $urandom_range(24, 2);
    case (fault)
      FAULT_ABOVE_MAX: begin
        write_reg(REG_MAX_LEN, '0);
        send_header($urandom());
      end
      FAULT_BELOW_MIN: begin
        write_reg(REG_MIN_LEN, 31'h7FFF_FFFF);
        send_header($urandom_range(400, 8));
      end
      FAULT_SHORT_BODY: begin
        write_reg(REG_MIN_LEN, '0);
        send_header($urandom_range(7, 0));
      end
      FAULT_CHECKSUM:   send_frame($urandom_range(mid, 2), mid, FILL_RANDOM, 1'b1);
      FAULT_NAME_SHORT: send_frame($urandom_range(1, 0), mid, FILL_RANDOM, 1'b0);
      FAULT_NAME_LONG:  send_frame(mid + $urandom_range(40, 1), mid, FILL_RANDOM, 1'b0);
      FAULT_NAME_NEG:   send_frame(32'h8000_0000 | $urandom(), mid, FILL_RANDOM, 1'b0);
      default:          send_frame(32'd0, mid, FILL_RANDOM, 1'b1);
    endcase
    // Everything after the fault must be swallowed.
    for (i = 0; i < 32; i++) send_byte($urandom_range(255, 0));
    drain_results();
  endtask

  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 10'd1;
    case (stall_tick[9:8])
      2'd0:    out_stall_i <= 1'b0;
      2'd1:    out_stall_i <= ($urandom_range(1, 0) == 1);
      2'd2:    out_stall_i <= (stall_tick[1:0] != 2'd0);
      default: out_stall_i <= ($urandom_range(7, 0) == 0);
    endcase
  end

  always @(posedge clk_i) begin : check_records
    frame_rec_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_records.size() == 0) begin
        report_mismatch($sformatf("unexpected record byte=%0h region=%0d status=%0d",
                                  out_byte_o, region_o, status_o));
      end else begin
        want = pending_records.pop_front();
        if (out_byte_o !== want.out_byte)
          report_mismatch($sformatf("out_byte %0h, wanted %0h", out_byte_o, want.out_byte));
        if (region_o !== want.region)
          report_mismatch($sformatf("region %0d, wanted %0d", region_o, want.region));
        if (status_o !== want.status)
          report_mismatch($sformatf("status %0d, wanted %0d", status_o, want.status));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles = idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = REG_MIN_LEN;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    data_byte_i  = 8'h00;
    out_stall_i  = 1'b0;
    stall_tick   = '0;
    mismatches   = 0;
    bytes_sent   = 0;
    burst_left   = 0;
    idle_cycles  = 0;
    min_len      = MIN_LEN_RST;
    max_len      = MAX_LEN_RST;
    frame_phase  = PH_HEADER;
    byte_cnt     = '0;
    frame_len    = '0;
    name_len     = '0;
    sum_field    = '0;
    run_sum.high = 16'd0;
    run_sum.low  = 16'd1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_bounds();
    test_sum_wrap();
    test_random();
    test_fault();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/acfd_pkg.sv
design/acfd_adler.sv
design/adler32_checked_frame_deframer_core.sv
bench/tb_adler32_checked_frame_deframer_core.sv
